>>> rtl/core/pva_pkg.sv
// ---------------------------------------------------------------------------
// pva_pkg: shared definitions for the priority voice allocator
// Function, result and register codes, gain constants, and the command and
// status bundles passed between the controller and the datapath.
// ---------------------------------------------------------------------------
package pva_pkg;

    localparam int MAX_CH_DEF = 8;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 8;
    localparam logic [CFG_IW-1:0] CFG_DEF_PRI = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_DEF_PAN = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_NOTIFY  = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_ACTIVE  = 2'd3;

    // request functions
    localparam logic [2:0] FUNC_PLAY   = 3'd0;
    localparam logic [2:0] FUNC_QUERY  = 3'd1;
    localparam logic [2:0] FUNC_END    = 3'd2;
    localparam logic [2:0] FUNC_KILL   = 3'd3;
    localparam logic [2:0] FUNC_DONE   = 3'd4;
    localparam logic [2:0] FUNC_RELOAD = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_PLAY   = 2'd0;
    localparam logic [1:0] KIND_QUERY  = 2'd1;
    localparam logic [1:0] KIND_NOTICE = 2'd2;
    localparam logic [1:0] KIND_RELOAD = 2'd3;

    // result status
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_CHAN = 2'd1;
    localparam logic [1:0] STAT_NO_DATA = 2'd2;

    // gain constants
    localparam logic [8:0] UNITY_GAIN = 9'h100;
    localparam logic [6:0] PAN_CENTER = 7'h40;
    localparam logic [6:0] PAN_MAX    = 7'h7F;

    localparam logic [7:0] RST_DEF_PRI = 8'd128;
    localparam logic [3:0] RST_ACTIVE  = 4'd8;

    // which result the datapath builds when told to emit
    typedef enum logic [2:0] {
        EM_NOTICE,
        EM_PLAY_OK,
        EM_PLAY_NODATA,
        EM_QUERY_OK,
        EM_FAIL,
        EM_RELOAD
    } t_emit;

    typedef struct packed {
        logic  load;
        logic  ptr_zero;
        logic  ptr_load_ch;
        logic  ptr_inc;
        logic  clr_busy;
        logic  commit;
        logic  emit;
        t_emit emit_sel;
        logic  last;
    } t_cmd;

    typedef struct packed {
        logic [2:0] func;
        logic       cnt_zero;
        logic       ch_in_range;
        logic       busy_at_ptr;
        logic       prio_below;
        logic       ptr_last;
        logic       more_busy;
        logic       notify;
        logic       has_data;
        logic       out_free;
    } t_stat;

endpackage

>>> rtl/core/pva_ctrl.sv
// ---------------------------------------------------------------------------
// pva_ctrl: request sequencer
// Decodes each request and walks the channel pointer through the idle scan,
// the steal scan and the kill-all sweep, issuing result emissions.
// ---------------------------------------------------------------------------
module pva_ctrl
    import pva_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_FREE   = 8'b0000_0100,
        S_STEAL  = 8'b0000_1000,
        S_FINISH = 8'b0001_0000,
        S_FAIL   = 8'b0010_0000,
        S_STOP   = 8'b0100_0000,
        S_KILL   = 8'b1000_0000
    } t_state;

    // reload shares the finish state; the r_reload flag tells them apart
    t_state r_state, n_state;
    logic   r_reload, n_reload;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_reload = r_reload;
        o_cmd    = '0;
        o_cmd.emit_sel = EM_FAIL;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_reload   = 1'b0;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.func)
                    FUNC_PLAY, FUNC_QUERY: begin
                        o_cmd.ptr_zero = 1'b1;
                        n_state = i_stat.cnt_zero ? S_FAIL : S_FREE;
                    end
                    FUNC_END, FUNC_DONE: begin
                        if (i_stat.ch_in_range) begin
                            o_cmd.ptr_load_ch = 1'b1;
                            n_state = S_STOP;
                        end
                    end
                    FUNC_KILL: begin
                        if (!i_stat.cnt_zero) begin
                            o_cmd.ptr_zero = 1'b1;
                            n_state = S_KILL;
                        end
                    end
                    FUNC_RELOAD: begin
                        if (i_stat.ch_in_range) begin
                            o_cmd.ptr_load_ch = 1'b1;
                            n_reload = 1'b1;
                            n_state  = S_FINISH;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_FREE: begin
                if (!i_stat.busy_at_ptr) begin
                    n_state = S_FINISH;
                end else if (i_stat.ptr_last) begin
                    o_cmd.ptr_zero = 1'b1;
                    n_state = S_STEAL;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_STEAL: begin
                if (i_stat.prio_below) begin
                    if (i_stat.func == FUNC_PLAY) begin
                        if (!i_stat.notify) begin
                            o_cmd.clr_busy = 1'b1;
                            n_state = S_FINISH;
                        end else if (i_stat.out_free) begin
                            // victim notice goes out ahead of the play result
                            o_cmd.clr_busy = 1'b1;
                            o_cmd.emit     = 1'b1;
                            o_cmd.emit_sel = EM_NOTICE;
                            n_state = S_FINISH;
                        end
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (i_stat.ptr_last) begin
                    n_state = S_FAIL;
                end else begin
                    o_cmd.ptr_inc = 1'b1;
                end
            end
            S_FINISH: begin
                if (r_reload) begin
                    o_cmd.emit_sel = EM_RELOAD;
                end else if (i_stat.func == FUNC_QUERY) begin
                    o_cmd.emit_sel = EM_QUERY_OK;
                end else begin
                    o_cmd.emit_sel = i_stat.has_data ? EM_PLAY_OK : EM_PLAY_NODATA;
                end
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.commit = !r_reload && (i_stat.func == FUNC_PLAY);
                    n_state = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_STOP: begin
                o_cmd.emit_sel = EM_NOTICE;
                if (i_stat.func == FUNC_END && i_stat.notify) begin
                    if (i_stat.out_free) begin
                        o_cmd.clr_busy = 1'b1;
                        o_cmd.emit     = 1'b1;
                        o_cmd.last     = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    o_cmd.clr_busy = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_KILL: begin
                o_cmd.emit_sel = EM_NOTICE;
                if (i_stat.busy_at_ptr && i_stat.notify) begin
                    // hold until the output slot frees up
                    if (i_stat.out_free) begin
                        o_cmd.clr_busy = 1'b1;
                        o_cmd.emit     = 1'b1;
                        o_cmd.last     = !i_stat.more_busy;
                        o_cmd.ptr_inc  = !i_stat.ptr_last;
                        n_state = i_stat.ptr_last ? S_IDLE : S_KILL;
                    end
                end else begin
                    o_cmd.clr_busy = 1'b1;
                    o_cmd.ptr_inc  = !i_stat.ptr_last;
                    n_state = i_stat.ptr_last ? S_IDLE : S_KILL;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_reload <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_reload <= n_reload;
        end
    end

endmodule

>>> rtl/core/pva_dp.sv
// ---------------------------------------------------------------------------
// pva_dp: allocator datapath
// Configuration registers, latched request, per-channel state, the scan
// pointer, the gain multipliers and the output register.
// ---------------------------------------------------------------------------
module pva_dp
    import pva_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic [2:0]        i_func,
    input  logic [2:0]        i_channel,
    input  logic [7:0]        i_priority_req,
    input  logic              i_override_valid,
    input  logic [6:0]        i_pan,
    input  logic [8:0]        i_volume,
    input  logic [15:0]       i_tag,
    input  logic              i_has_data,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_status,
    output logic [2:0]        o_result_channel,
    output logic [8:0]        o_left_gain,
    output logic [8:0]        o_right_gain,
    output logic [15:0]       o_result_tag,
    output logic              o_last
);

    localparam int IW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CW0 = $clog2(MAX_CHANNELS + 1);
    localparam int CW  = (CW0 > 4) ? CW0 : 4;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_CHANNELS);

    // configuration
    logic [7:0] r_def_pri;
    logic [6:0] r_def_pan;
    logic       r_notify;
    logic [3:0] r_active;

    // latched request
    logic [2:0]  r_func;
    logic [2:0]  r_ch;
    logic [7:0]  r_pri;
    logic [6:0]  r_pan;
    logic [8:0]  r_vol;
    logic [15:0] r_tag;
    logic        r_data;

    // channel state
    logic [MAX_CHANNELS-1:0] r_busy;
    logic [7:0]              r_cprio [MAX_CHANNELS];
    logic [15:0]             r_ctag  [MAX_CHANNELS];
    logic [6:0]              r_cpan  [MAX_CHANNELS];
    logic [8:0]              r_cvol  [MAX_CHANNELS];

    logic [IW-1:0] r_ptr, n_ptr;

    logic [CW-1:0] w_active;
    logic [CW-1:0] w_live;
    logic [CW-1:0] w_ptr_ext;
    logic          w_more;

    logic [6:0]  g_pan;
    logic [8:0]  g_vol;
    logic [8:0]  g_base_l, g_base_r;
    logic [16:0] g_prod_l, g_prod_r;
    logic [8:0]  g_left, g_right;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_def_pri <= RST_DEF_PRI;
            r_def_pan <= PAN_CENTER;
            r_notify  <= 1'b1;
            r_active  <= RST_ACTIVE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DEF_PRI: r_def_pri <= i_cfg_data[7:0];
                CFG_DEF_PAN: r_def_pan <= i_cfg_data[6:0];
                CFG_NOTIFY:  r_notify  <= i_cfg_data[0];
                CFG_ACTIVE:  r_active  <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // resolve defaults while latching the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_ch   <= i_channel;
            r_pri  <= (i_func == FUNC_PLAY && !i_override_valid) ? r_def_pri
                                                                 : i_priority_req;
            r_pan  <= i_override_valid ? i_pan : r_def_pan;
            r_vol  <= i_override_valid ? i_volume : UNITY_GAIN;
            r_tag  <= i_tag;
            r_data <= i_has_data;
        end
    end

    // scan pointer
    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.ptr_zero) begin
            n_ptr = '0;
        end else if (i_cmd.ptr_load_ch) begin
            n_ptr = IW'(r_ch);
        end else if (i_cmd.ptr_inc) begin
            n_ptr = r_ptr + IW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else begin
            r_ptr <= n_ptr;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_cprio[i] <= '0;
                r_ctag[i]  <= '0;
                r_cpan[i]  <= PAN_CENTER;
                r_cvol[i]  <= UNITY_GAIN;
            end
        end else if (i_cmd.commit) begin
            r_busy[r_ptr]  <= r_data;
            r_cprio[r_ptr] <= r_pri;
            r_cpan[r_ptr]  <= r_pan;
            r_cvol[r_ptr]  <= r_vol;
            r_ctag[r_ptr]  <= r_data ? r_tag : 16'd0;
        end else if (i_cmd.clr_busy) begin
            r_busy[r_ptr] <= 1'b0;
        end
    end

    // active count saturates at the channel count
    assign w_active  = CW'(r_active);
    assign w_live    = (w_active > MAX_CNT) ? MAX_CNT : w_active;
    assign w_ptr_ext = CW'(r_ptr);

    // any busy channel past the pointer, for the last flag of kill-all
    always_comb begin
        w_more = 1'b0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (CW'(i) < w_live && CW'(i) > w_ptr_ext && r_busy[i]) begin
                w_more = 1'b1;
            end
        end
    end

    always_comb begin
        o_stat.func        = r_func;
        o_stat.cnt_zero    = (w_live == '0);
        o_stat.ch_in_range = (CW'(r_ch) < w_live);
        o_stat.busy_at_ptr = r_busy[r_ptr];
        o_stat.prio_below  = (r_cprio[r_ptr] < r_pri);
        o_stat.ptr_last    = ((w_ptr_ext + CW'(1)) == w_live);
        o_stat.more_busy   = w_more;
        o_stat.notify      = r_notify;
        o_stat.has_data    = r_data;
        o_stat.out_free    = !o_out_valid || i_out_ready;
    end

    // gains: pan sets the base, volume below unity scales it down
    always_comb begin
        if (i_cmd.emit_sel == EM_RELOAD) begin
            g_pan = r_cpan[r_ptr];
            g_vol = r_cvol[r_ptr];
        end else begin
            g_pan = r_pan;
            g_vol = r_vol;
        end
        g_base_l = UNITY_GAIN;
        g_base_r = UNITY_GAIN;
        if (g_pan < PAN_CENTER) begin
            g_base_r = {g_pan, 2'b00};
        end else if (g_pan > PAN_CENTER) begin
            g_base_l = {PAN_MAX - g_pan, 2'b00};
        end
        g_prod_l = g_base_l * g_vol[7:0];
        g_prod_r = g_base_r * g_vol[7:0];
        if (g_vol < UNITY_GAIN) begin
            g_left  = g_prod_l[16:8];
            g_right = g_prod_r[16:8];
        end else begin
            g_left  = g_base_l;
            g_right = g_base_r;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_last           <= i_cmd.last;
            o_status         <= STAT_OK;
            o_result_channel <= 3'(r_ptr);
            o_left_gain      <= '0;
            o_right_gain     <= '0;
            o_result_tag     <= '0;
            case (i_cmd.emit_sel)
                EM_NOTICE: begin
                    o_kind       <= KIND_NOTICE;
                    o_result_tag <= r_ctag[r_ptr];
                end
                EM_PLAY_OK: begin
                    o_kind       <= KIND_PLAY;
                    o_left_gain  <= g_left;
                    o_right_gain <= g_right;
                end
                EM_PLAY_NODATA: begin
                    o_kind   <= KIND_PLAY;
                    o_status <= STAT_NO_DATA;
                end
                EM_QUERY_OK: begin
                    o_kind <= KIND_QUERY;
                end
                EM_RELOAD: begin
                    o_kind       <= KIND_RELOAD;
                    o_left_gain  <= g_left;
                    o_right_gain <= g_right;
                end
                default: begin
                    o_kind           <= (r_func == FUNC_QUERY) ? KIND_QUERY : KIND_PLAY;
                    o_status         <= STAT_NO_CHAN;
                    o_result_channel <= '0;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/priority_voice_allocator_top.sv
// Sequential: one request in flight, o_in_ready is high only in IDLE. Play and query go
// through take, decode, a scan of the active channels for an idle one, a second scan for a
// steal victim if none is idle, then the result; with no active channels the result follows
// decode. Kill-all sweeps the active channels after decode; end, done and reload act after
// decode. The result that closes a play, query, reload or end request becomes valid in the
// same cycle that o_in_ready returns high. Each emission also waits out output stalls.
// Reset (synchronous, active low) idles every channel and restores defaults.
// priority_voice_allocator_top: voice-stealing channel allocator
// Allocates sound channels by priority, issues finish notices for stopped
// channels and reports left and right gains from pan and volume.
// ---------------------------------------------------------------------------
module priority_voice_allocator_top
    import pva_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_func,
    input  logic [2:0]        i_channel,
    input  logic [7:0]        i_priority_req,
    input  logic              i_override_valid,
    input  logic [6:0]        i_pan,
    input  logic [8:0]        i_volume,
    input  logic [15:0]       i_tag,
    input  logic              i_has_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_status,
    output logic [2:0]        o_result_channel,
    output logic [8:0]        o_left_gain,
    output logic [8:0]        o_right_gain,
    output logic [15:0]       o_result_tag,
    output logic              o_last
);

    t_cmd  w_cmd;
    t_stat w_stat;

    pva_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    pva_dp #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_func           (i_func),
        .i_channel        (i_channel),
        .i_priority_req   (i_priority_req),
        .i_override_valid (i_override_valid),
        .i_pan            (i_pan),
        .i_volume         (i_volume),
        .i_tag            (i_tag),
        .i_has_data       (i_has_data),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_status         (o_status),
        .o_result_channel (o_result_channel),
        .o_left_gain      (o_left_gain),
        .o_right_gain     (o_right_gain),
        .o_result_tag     (o_result_tag),
        .o_last           (o_last)
    );

endmodule

>>> rtl/core/pva_checker.sv
// ---------------------------------------------------------------------------
// pva_checker: port-level checks for the voice allocator
// Watches the top-level ports for output hold, request sequencing and the
// zeroed fields of notices and failed allocations, and the gain range.
// ---------------------------------------------------------------------------
module pva_checker
    import pva_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        o_kind,
    input logic [1:0]        o_status,
    input logic [2:0]        o_result_channel,
    input logic [8:0]        o_left_gain,
    input logic [8:0]        o_right_gain,
    input logic [15:0]       o_result_tag,
    input logic              o_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_status) && $stable(o_result_channel)
            && $stable(o_left_gain) && $stable(o_right_gain)
            && $stable(o_result_tag) && $stable(o_last))
        else $error("result changed while stalled");

    // an accepted request drops o_in_ready in the following cycle, so requests cannot go in back to back
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request accepted back to back");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == STAT_NO_CHAN |-> o_result_channel == 3'd0
            && o_left_gain == 9'd0 && o_right_gain == 9'd0
            && o_result_tag == 16'd0 && o_last)
        else $error("failed allocation carries data");

    a_notice_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_NOTICE |-> o_status == STAT_OK
            && o_left_gain == 9'd0 && o_right_gain == 9'd0)
        else $error("notice carries gains");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_left_gain <= UNITY_GAIN && o_right_gain <= UNITY_GAIN)
        else $error("gain above unity");

endmodule

bind priority_voice_allocator_top pva_checker u_pva_checker (.*);
